>>> sv/lsra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_pkg
// Shared types and constants of the linear scan register allocator.
// ----------------------------------------------------------------------------
package lsra_pkg;

   localparam int MAX_SPAN    = 4;
   localparam int SPAN_W      = 3;
   localparam int IDX_W       = 8;
   localparam int CFG_REGS_W  = 9;
   localparam int CFG_PREDS_W = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 9;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_REGISTERS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PREDICATES = 2'd1;

   localparam logic [CFG_REGS_W-1:0]  RST_MAX_REGISTERS  = 9'd256;
   localparam logic [CFG_PREDS_W-1:0] RST_MAX_PREDICATES = 4'd7;

   // controller to datapath
   typedef struct packed {
      logic idle;       // ready for a new interval
      logic rd_head;    // read the head of the active list
      logic release_hd; // free the head entry and pop it
      logic srch_step;  // evaluate one candidate
      logic mark;       // claim the found resource, prime insertion
      logic rd_ins;     // read the entry below the insertion point
      logic shift;      // move that entry up one place
      logic put;        // write the new entry
      logic emit;       // load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;
      logic head_expired;
      logic srch_fail;
      logic srch_hit;
      logic list_full;
      logic ins_zero;
      logic ins_move;
      logic rsp_busy;
   } sts_type;

endpackage

>>> sv/lsra_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_req_if
// Interval request channel.
// ----------------------------------------------------------------------------
interface lsra_req_if #(parameter int POS_WIDTH = 16);
   logic                 valid;
   logic                 ready;
   logic                 new_function;
   logic [POS_WIDTH-1:0] interval_start;
   logic [POS_WIDTH-1:0] interval_end;
   logic                 is_predicate;
   logic [2:0]           reg_span;

   modport source (output valid, new_function, interval_start, interval_end,
                   is_predicate, reg_span, input ready);
   modport sink   (input valid, new_function, interval_start, interval_end,
                   is_predicate, reg_span, output ready);
endinterface

>>> sv/lsra_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_rsp_if
// Allocation result channel.
// ----------------------------------------------------------------------------
interface lsra_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] assigned_index;
   logic       out_of_registers;

   modport source (output valid, assigned_index, out_of_registers, input ready);
   modport sink   (input valid, assigned_index, out_of_registers, output ready);
endinterface

>>> sv/lsra_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_csr_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface lsra_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [8:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/lsra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_ctrl
// Sequencer: release walk, busy map search, sorted insertion, result.
// ----------------------------------------------------------------------------
module lsra_ctrl
   import lsra_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_fire,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_REL_RD, ST_REL_CMP, ST_SRCH, ST_INS_CHK,
      ST_INS_RD, ST_INS_CMP, ST_INS_PUT, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (req_fire) state_in = ST_REL_RD;
         end
         ST_REL_RD: begin
            if (sts.count_zero) begin
               state_in = ST_SRCH;
            end else begin
               cmd.rd_head = 1'b1;
               state_in    = ST_REL_CMP;
            end
         end
         ST_REL_CMP: begin
            if (sts.head_expired) begin
               cmd.release_hd = 1'b1;
               state_in       = ST_REL_RD;
            end else begin
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            cmd.srch_step = 1'b1;
            if (sts.srch_fail) begin
               state_in = ST_DONE;
            end else if (sts.srch_hit) begin
               cmd.mark = 1'b1;
               state_in = sts.list_full ? ST_DONE : ST_INS_CHK;
            end
         end
         ST_INS_CHK: begin
            state_in = sts.ins_zero ? ST_INS_PUT : ST_INS_RD;
         end
         ST_INS_RD: begin
            cmd.rd_ins = 1'b1;
            state_in   = ST_INS_CMP;
         end
         ST_INS_CMP: begin
            if (sts.ins_move) begin
               cmd.shift = 1'b1;
               state_in  = ST_INS_CHK;
            end else begin
               cmd.put  = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_INS_PUT: begin
            cmd.put  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/lsra_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_dp
// Datapath: busy maps, active list memory, candidate search, result register.
// ----------------------------------------------------------------------------
module lsra_dp
   import lsra_pkg::*;
#(
   parameter int NUM_REGS  = 256,
   parameter int NUM_PREDS = 8,
   parameter int POS_WIDTH = 16
) (
   input  logic           clock,
   input  logic           reset,
   lsra_req_if.sink       req_ch,
   lsra_rsp_if.source     rsp_ch,
   lsra_csr_if.sink       csr_ch,
   input  cmd_type        cmd,
   output sts_type        sts,
   output logic           req_fire
);

   localparam int DEPTH = NUM_REGS + NUM_PREDS;
   localparam int AW    = $clog2(DEPTH);
   localparam int MEMD  = 2 ** AW;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMAX  = (NUM_REGS + MAX_SPAN > NUM_PREDS) ? NUM_REGS + MAX_SPAN
                                                            : NUM_PREDS;
   localparam int CW    = $clog2(CMAX + 1);
   localparam int RW    = $clog2(NUM_REGS);
   localparam int EW    = POS_WIDTH + IDX_W + SPAN_W;

   logic [CFG_REGS_W-1:0]  cfg_regs_ff;
   logic [CFG_PREDS_W-1:0] cfg_preds_ff;
   logic                   is_pred_ff;
   logic [SPAN_W-1:0]      span_ff;
   logic [POS_WIDTH-1:0]   start_ff, end_ff;
   logic [NUM_REGS-1:0]    reg_busy_ff;
   logic [NUM_PREDS-1:0]   pred_busy_ff;
   logic [AW-1:0]          head_ff;
   logic [CNT_W-1:0]       count_ff, ins_i_ff;
   logic [CW-1:0]          cand_ff;
   logic                   fail_ff;
   logic [EW-1:0]          mem [MEMD];
   logic [EW-1:0]          rdata_ff;
   logic                   rsp_valid_ff;
   logic [IDX_W-1:0]       rsp_idx_ff;
   logic                   rsp_oor_ff;

   logic [SPAN_W-1:0]      req_span;
   logic [CW-1:0]          r_lim, p_lim, cand_top;
   logic                   p_bit, r_bits, s_fail;
   logic [POS_WIDTH-1:0]   r_end;
   logic [IDX_W-1:0]       r_first;
   logic [SPAN_W-1:0]      r_span;
   logic [AW-1:0]          raddr, waddr;
   logic                   we;
   logic [EW-1:0]          wdata, new_entry;

   assign req_fire     = req_ch.valid & req_ch.ready;
   assign req_ch.ready = cmd.idle;
   assign csr_ch.ready = 1'b1;

   assign r_end   = rdata_ff[EW-1 -: POS_WIDTH];
   assign r_first = rdata_ff[SPAN_W +: IDX_W];
   assign r_span  = rdata_ff[SPAN_W-1:0];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_regs_ff  <= RST_MAX_REGISTERS;
         cfg_preds_ff <= RST_MAX_PREDICATES;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == CSR_MAX_REGISTERS) begin
            cfg_regs_ff <= csr_ch.data;
         end else if (csr_ch.index == CSR_MAX_PREDICATES) begin
            cfg_preds_ff <= csr_ch.data[CFG_PREDS_W-1:0];
         end
      end
   end

   // clamp span and limits
   always_comb begin
      if (req_ch.reg_span == '0)                      req_span = SPAN_W'(1);
      else if (req_ch.reg_span > SPAN_W'(MAX_SPAN))   req_span = SPAN_W'(MAX_SPAN);
      else                                            req_span = req_ch.reg_span;
      r_lim = (int'(cfg_regs_ff) > NUM_REGS) ? CW'(NUM_REGS) : CW'(cfg_regs_ff);
      p_lim = (int'(cfg_preds_ff) > NUM_PREDS) ? CW'(NUM_PREDS) : CW'(cfg_preds_ff);
   end

   // test the current candidate
   always_comb begin
      logic [CW-1:0] idx;
      p_bit  = 1'b0;
      r_bits = 1'b0;
      for (int j = 0; j < NUM_PREDS; j++) begin
         if (cand_ff == CW'(j)) p_bit = pred_busy_ff[j];
      end
      for (int k = 0; k < MAX_SPAN; k++) begin
         idx = cand_ff + CW'(k);
         if (k < int'(span_ff) && int'(idx) < NUM_REGS) begin
            if (reg_busy_ff[idx[RW-1:0]]) r_bits = 1'b1;
         end
      end
      cand_top = cand_ff + CW'(span_ff) - CW'(1);
      s_fail   = is_pred_ff ? (cand_ff >= p_lim) : (cand_top >= r_lim);
   end

   assign sts.count_zero   = (count_ff == '0);
   assign sts.head_expired = (r_end < start_ff);
   assign sts.srch_fail    = s_fail;
   assign sts.srch_hit     = !s_fail && !(is_pred_ff ? p_bit : r_bits);
   assign sts.list_full    = (int'(count_ff) >= DEPTH);
   assign sts.ins_zero     = (ins_i_ff == '0);
   assign sts.ins_move     = (end_ff < r_end);
   assign sts.rsp_busy     = rsp_valid_ff & ~rsp_ch.ready;

   // request capture, search, list bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         reg_busy_ff  <= '0;
         pred_busy_ff <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
      end else begin
         if (req_fire) begin
            is_pred_ff <= req_ch.is_predicate;
            span_ff    <= req_ch.is_predicate ? SPAN_W'(1) : req_span;
            start_ff   <= req_ch.interval_start;
            end_ff     <= req_ch.interval_end;
            cand_ff    <= '0;
            fail_ff    <= 1'b0;
            if (req_ch.new_function) begin
               reg_busy_ff  <= '0;
               pred_busy_ff <= '0;
               count_ff     <= '0;
            end
         end
         // free the head entry
         if (cmd.release_hd) begin
            if (r_span == '0) begin
               for (int j = 0; j < NUM_PREDS; j++) begin
                  if (r_first == IDX_W'(j)) pred_busy_ff[j] <= 1'b0;
               end
            end else begin
               for (int k = 0; k < MAX_SPAN; k++) begin
                  if (k < int'(r_span) && int'(r_first) + k < NUM_REGS) begin
                     reg_busy_ff[RW'(int'(r_first) + k)] <= 1'b0;
                  end
               end
            end
            head_ff  <= head_ff + AW'(1);
            count_ff <= count_ff - CNT_W'(1);
         end
         // advance the search or claim the hit
         if (cmd.srch_step) begin
            if (s_fail) begin
               fail_ff <= 1'b1;
            end else if (!cmd.mark) begin
               cand_ff <= cand_ff + CW'(span_ff);
            end
         end
         if (cmd.mark) begin
            if (is_pred_ff) begin
               for (int j = 0; j < NUM_PREDS; j++) begin
                  if (cand_ff == CW'(j)) pred_busy_ff[j] <= 1'b1;
               end
            end else begin
               for (int k = 0; k < MAX_SPAN; k++) begin
                  if (k < int'(span_ff) && int'(cand_ff) + k < NUM_REGS) begin
                     reg_busy_ff[RW'(int'(cand_ff) + k)] <= 1'b1;
                  end
               end
            end
            ins_i_ff <= count_ff;
         end
         if (cmd.shift) ins_i_ff <= ins_i_ff - CNT_W'(1);
         if (cmd.put)   count_ff <= count_ff + CNT_W'(1);
      end
   end

   // active list memory ports
   assign new_entry = {end_ff, IDX_W'(cand_ff), is_pred_ff ? SPAN_W'(0) : span_ff};
   assign raddr = cmd.rd_head ? head_ff : head_ff + AW'(ins_i_ff - CNT_W'(1));
   assign waddr = head_ff + AW'(ins_i_ff);
   assign we    = cmd.shift | cmd.put;
   assign wdata = cmd.shift ? rdata_ff : new_entry;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_idx_ff <= fail_ff ? '0 : IDX_W'(cand_ff);
         rsp_oor_ff <= fail_ff;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.assigned_index   = rsp_idx_ff;
   assign rsp_ch.out_of_registers = rsp_oor_ff;

endmodule

>>> sv/linear_scan_register_allocator_unit.sv
`timescale 1ns / 1ps
// Sequence: from transfer to result, expired entries are released from the head,
//   candidates are tried (one a cycle), and later-ending entries are moved up to
//   make room for the sorted insertion; on exhaustion no insertion is made.
// Throughput: one interval at a time; the next request is taken while a result
//   waits in the output register.
// Reset (synchronous): busy maps and list count clear at once, no sweep.
// ----------------------------------------------------------------------------
// linear_scan_register_allocator_unit
// Linear scan register and predicate allocator over sorted live intervals.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_unit
   import lsra_pkg::*;
#(
   parameter int NUM_REGS  = 256,
   parameter int NUM_PREDS = 8,
   parameter int POS_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   lsra_req_if.sink   req_ch,
   lsra_rsp_if.source rsp_ch,
   lsra_csr_if.sink   csr_ch
);

   cmd_type cmd;
   sts_type sts;
   logic    req_fire;

   lsra_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .sts      (sts),
      .cmd      (cmd)
   );

   lsra_dp #(
      .NUM_REGS  (NUM_REGS),
      .NUM_PREDS (NUM_PREDS),
      .POS_WIDTH (POS_WIDTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_ch   (csr_ch),
      .cmd      (cmd),
      .sts      (sts),
      .req_fire (req_fire)
   );

`ifndef SYNTHESIS
   // a result is never loaded over one still stalled
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_ch.valid && !rsp_ch.ready))
      else $error("result loaded over a stalled transfer");

   // an accepted interval makes the block busy
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ch.ready)
      else $error("request taken while busy");

   // a loaded result is offered on the next cycle
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_ch.valid)
      else $error("result not offered");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the linear scan register allocator. A directed table
// covers reset values, field extremes, span clamping, limit clamping and
// exhaustion. It is followed by random well-formed functions with some noise,
// under several limit settings. Each result is checked against a predictor
// that runs alongside the block.
// ----------------------------------------------------------------------------
module tb;
   import lsra_pkg::*;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      logic        nf;
      logic [15:0] start;
      logic [15:0] last;
      logic        pred;
      logic [2:0]  span;
   } ivl_type;

   typedef struct {
      logic [7:0] idx;
      logic       oor;
   } alloc_type;

   typedef struct {
      logic [15:0] last;
      int          first;
      int          span;
   } live_type;

   typedef struct {
      row_kind_type             kind;
      ivl_type                  ivl;
      logic [CSR_IDX_W-1:0]     csr_idx;
      logic [CSR_DATA_W-1:0]    csr_data;
      bit                       known;
      alloc_type                res;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lsra_req_if #(.POS_WIDTH(16)) req_ch ();
   lsra_rsp_if rsp_ch ();
   lsra_csr_if csr_ch ();

   linear_scan_register_allocator_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state
   logic [255:0]          reg_busy;
   logic [7:0]            pred_busy;
   live_type              live_q[$];
   logic [CFG_REGS_W-1:0]  lim_regs;
   logic [CFG_PREDS_W-1:0] lim_preds;

   alloc_type alloc_q[$];
   int     n_errors = 0;
   int     n_sent = 0;
   int     n_seen = 0;
   int     n_oor = 0;
   int     n_pred = 0;
   bit     hold_off = 1'b0;
   int     stall_mode = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #20000000;
      $display("timeout after %0d results", n_seen);
      $display("tb failed");
      $finish;
   end

   task automatic report(input string what);
      n_errors++;
      $display("mismatch at result %0d: %s", n_seen, what);
   endtask

   // work out the allocation of one interval and update the predictor
   task automatic predict_alloc(input ivl_type r, output alloc_type a);
      int       lim;
      int       idx;
      int       sp;
      int       pos;
      bit       ok;
      bit       found;
      live_type e;
      if (r.nf) begin
         reg_busy  = '0;
         pred_busy = '0;
         live_q.delete();
      end
      // drop expired entries from the head
      while (live_q.size() > 0 && live_q[0].last < r.start) begin
         e = live_q.pop_front();
         if (e.span == 0) pred_busy[e.first] = 1'b0;
         else for (int i = e.first; i < e.first + e.span; i++) reg_busy[i] = 1'b0;
      end
      idx   = 0;
      found = 1'b0;
      if (r.pred) begin
         lim = (lim_preds > 8) ? 8 : lim_preds;
         sp  = 0;
         while (idx < lim && pred_busy[idx]) idx++;
         if (idx < lim) begin
            found = 1'b1;
            pred_busy[idx] = 1'b1;
         end
      end else begin
         lim = (lim_regs > 256) ? 256 : lim_regs;
         sp  = (r.span == 0) ? 1 : (r.span > 4) ? 4 : r.span;
         while (idx < lim) begin
            if (idx + sp - 1 >= lim) break;
            ok = 1'b1;
            for (int i = idx; i < idx + sp; i++) if (reg_busy[i]) ok = 1'b0;
            if (ok) begin
               found = 1'b1;
               break;
            end
            idx += sp;
         end
         if (found) for (int i = idx; i < idx + sp; i++) reg_busy[i] = 1'b1;
      end
      // insert by end, after equal ends
      if (found) begin
         pos = 0;
         while (pos < live_q.size() && !(r.last < live_q[pos].last)) pos++;
         e.last  = r.last;
         e.first = idx;
         e.span  = sp;
         live_q.insert(pos, e);
      end
      a.idx = found ? idx[7:0] : 8'd0;
      a.oor = !found;
   endtask

   // offer one interval and hold it until the transfer
   task automatic send_ivl(input ivl_type r, input bit known, input alloc_type want);
      alloc_type a;
      req_ch.valid          <= 1'b1;
      req_ch.new_function   <= r.nf;
      req_ch.interval_start <= r.start;
      req_ch.interval_end   <= r.last;
      req_ch.is_predicate   <= r.pred;
      req_ch.reg_span       <= r.span;
      do @(posedge clock); while (!req_ch.ready);
      predict_alloc(r, a);
      if (known && (a.idx !== want.idx || a.oor !== want.oor))
         report($sformatf("table row expects %0d/%0d, predictor %0d/%0d",
                          want.idx, want.oor, a.idx, a.oor));
      alloc_q.push_back(a);
      n_sent++;
      if (r.pred) n_pred++;
   endtask

   task automatic idle_req(input int n);
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // drain, then write one limit register
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      idle_req(1);
      while (alloc_q.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_MAX_REGISTERS) lim_regs = data[CFG_REGS_W-1:0];
      else if (idx == CSR_MAX_PREDICATES) lim_preds = data[CFG_PREDS_W-1:0];
   endtask

   function automatic row_type rq(logic nf, logic [15:0] s, logic [15:0] e, logic p,
                                  logic [2:0] sp, bit known = 0, logic [7:0] idx = 0,
                                  logic oor = 0);
      row_type t;
      t.kind = ROW_REQ;
      t.ivl  = '{nf, s, e, p, sp};
      t.csr_idx = CSR_MAX_REGISTERS;
      t.csr_data = '0;
      t.known = known;
      t.res = '{idx, oor};
      return t;
   endfunction

   function automatic row_type wr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      row_type t;
      t = rq(0, 0, 0, 0, 0);
      t.kind = ROW_CSR;
      t.csr_idx = idx;
      t.csr_data = d;
      return t;
   endfunction

   function automatic ivl_type rand_ivl(ref int pos, input bit nf);
      ivl_type r;
      if ($urandom_range(0, 9) == 0) begin
         // noise: any field value, order broken
         r.nf    = ($urandom_range(0, 7) == 0);
         r.start = $urandom;
         r.last  = $urandom;
         r.pred  = $urandom;
         r.span  = $urandom;
      end else begin
         r.nf    = nf;
         pos    += $urandom_range(0, 3);
         if (pos > 65535) pos = 65535;
         r.start = pos;
         r.last  = (pos + $urandom_range(0, 48) > 65535) ? 16'hFFFF
                   : pos + $urandom_range(0, 48);
         r.pred  = ($urandom_range(0, 3) == 0);
         r.span  = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(1, 4);
      end
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      alloc_type w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_seen++;
         if (alloc_q.size() == 0) begin
            report("result with nothing expected");
         end else begin
            w = alloc_q.pop_front();
            if (rsp_ch.assigned_index !== w.idx)
               report($sformatf("assigned_index %0d, expected %0d",
                                rsp_ch.assigned_index, w.idx));
            if (rsp_ch.out_of_registers !== w.oor)
               report($sformatf("out_of_registers %0b, expected %0b",
                                rsp_ch.out_of_registers, w.oor));
            if (w.oor) n_oor++;
         end
      end
   end

   // receiver stall pattern; the mode changes at random
   always @(posedge clock) begin
      if (($urandom & 63) == 0) stall_mode <= $urandom_range(0, 2);
      if (hold_off) rsp_ch.ready <= 1'b0;
      else case (stall_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= $urandom;
         default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   // one long hold-off while the sender keeps offering
   initial begin
      wait (n_sent == 200);
      hold_off = 1'b1;
      repeat (3000) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      row_type   dir[$];
      ivl_type   r;
      alloc_type none;
      int        pos;
      int        burst;
      int        wait_cnt;
      logic [8:0]  regs_set[6];
      logic [8:0]  preds_set[6];

      regs_set  = '{9'd256, 9'd8, 9'd1, 9'd511, 9'd13, 9'd255};
      preds_set = '{9'd7, 9'd2, 9'd1, 9'd15, 9'd0, 9'd8};
      burst = 0;
      req_ch.valid <= 1'b0;
      req_ch.new_function <= 1'b0;
      req_ch.interval_start <= '0;
      req_ch.interval_end <= '0;
      req_ch.is_predicate <= 1'b0;
      req_ch.reg_span <= 3'd1;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_MAX_REGISTERS;
      csr_ch.data <= '0;
      reg_busy  = '0;
      pred_busy = '0;
      lim_regs  = RST_MAX_REGISTERS;
      lim_preds = RST_MAX_PREDICATES;
      none = '{8'd0, 1'b0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      dir.push_back(rq(1, 16'd0, 16'd10, 0, 3'd1, 1, 8'd0, 0));
      dir.push_back(rq(0, 16'd0, 16'd10, 0, 3'd2, 1, 8'd2, 0));
      dir.push_back(rq(0, 16'd1, 16'd5, 0, 3'd4, 1, 8'd4, 0));
      dir.push_back(rq(0, 16'd1, 16'hFFFF, 1, 3'd0, 1, 8'd0, 0));
      dir.push_back(rq(0, 16'd2, 16'd3, 1, 3'd7, 1, 8'd1, 0));
      dir.push_back(rq(0, 16'd4, 16'd4, 0, 3'd0));
      dir.push_back(rq(0, 16'd5, 16'd9, 0, 3'd7));
      dir.push_back(rq(0, 16'd6, 16'd6, 0, 3'd3));
      dir.push_back(rq(0, 16'd3, 16'd100, 0, 3'd5));
      dir.push_back(wr(CSR_MAX_PREDICATES, 9'd1));
      dir.push_back(rq(0, 16'd7, 16'd7, 1, 3'd1, 1, 8'd0, 1));
      dir.push_back(wr(CSR_MAX_REGISTERS, 9'd0));
      dir.push_back(rq(0, 16'd8, 16'd8, 0, 3'd1, 1, 8'd0, 1));
      dir.push_back(wr(CSR_MAX_PREDICATES, 9'd0));
      dir.push_back(rq(1, 16'd0, 16'd0, 1, 3'd1, 1, 8'd0, 1));
      dir.push_back(wr(CSR_MAX_REGISTERS, 9'd511));
      dir.push_back(wr(CSR_MAX_PREDICATES, 9'd15));
      dir.push_back(rq(1, 16'd0, 16'd0, 0, 3'd4, 1, 8'd0, 0));
      dir.push_back(rq(0, 16'd0, 16'hFFFF, 1, 3'd1, 1, 8'd0, 0));
      dir.push_back(rq(0, 16'd1, 16'hFFFF, 1, 3'd6));
      dir.push_back(wr(CSR_MAX_REGISTERS, 9'd1));
      dir.push_back(rq(1, 16'hFFFF, 16'hFFFF, 0, 3'd2, 1, 8'd0, 1));
      dir.push_back(rq(0, 16'hFFFF, 16'hFFFF, 0, 3'd1, 1, 8'd0, 0));
      dir.push_back(rq(0, 16'hFFFF, 16'hFFFF, 0, 3'd1, 1, 8'd0, 1));
      dir.push_back(rq(0, 16'hFFFF, 16'd0, 1, 3'd1, 1, 8'd0, 0));

      foreach (dir[i]) begin
         if (dir[i].kind == ROW_CSR) write_csr(dir[i].csr_idx, dir[i].csr_data);
         else begin
            send_ivl(dir[i].ivl, dir[i].known, dir[i].res);
            idle_req($urandom_range(0, 2));
         end
      end

      // random phases, one limit setting each
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_MAX_REGISTERS, regs_set[ph]);
         write_csr(CSR_MAX_PREDICATES, preds_set[ph]);
         pos = $urandom_range(0, 65000);
         for (int k = 0; k < 80; k++) begin
            if (k % 20 == 0) pos = $urandom_range(0, 65000);
            r = rand_ivl(pos, (k % 20 == 0));
            send_ivl(r, 0, none);
            if (burst > 0) burst--;
            else begin
               burst = $urandom_range(1, 20);
               idle_req($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
            end
         end
      end
      idle_req(1);

      // drain with a limit, then let the block settle
      wait_cnt = 0;
      while (alloc_q.size() > 0 && wait_cnt < 200000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (2000) @(posedge clock);
      if (alloc_q.size() > 0) report($sformatf("%0d results never came", alloc_q.size()));

      $display("sent %0d intervals (%0d predicates), checked %0d results",
               n_sent, n_pred, n_seen);
      $display("exhausted %0d times over %0d limit settings", n_oor, 6);
      if (n_errors == 0) begin
         $display("tb passed");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("tb failed");
      end
      $finish;
   end

endmodule
